### hdl/assert_macros.svh
// Assertion macros used by the core RTL file of the rate limiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/swerl_pkg.sv
// Types and constants of the sliding-window rate limiter.
package swerl_pkg;

    localparam int STAMP_W     = 32;
    localparam int FRAME_W     = 32;
    localparam int CLASS_W     = 8;
    localparam int WINDOW_W    = 16;
    localparam int LIMIT_W     = 6;
    localparam int CAUSE_W     = 2;
    localparam int COUNT_OUT_W = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 6'd20;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_WINDOW = 2'd1;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_DUP  = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_INSERT,
        ST_EMIT
    } state_t;

    typedef enum logic {
        PASS_COUNT,
        PASS_INSERT
    } pass_t;

    // Token that walks down the cell row, one cell per cycle.
    typedef struct packed {
        logic               active;
        pass_t              kind;
        logic               prune;
        logic               done;
        logic [STAMP_W-1:0] now;
    } token_t;

endpackage

### hdl/swerl_cell.sv
// One slot of the grant log: holds a stamp, ages it and passes the token on.
module swerl_cell #(
    parameter int CNT_W = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [swerl_pkg::WINDOW_W-1:0] window_ms,
    input  swerl_pkg::token_t              tok_in,
    input  logic [CNT_W-1:0]               cnt_in,
    output swerl_pkg::token_t              tok_out,
    output logic [CNT_W-1:0]               cnt_out
);

    logic [swerl_pkg::STAMP_W-1:0] stamp_reg;
    logic [swerl_pkg::STAMP_W-1:0] stamp_next;
    logic                          valid_reg;
    logic                          valid_next;
    swerl_pkg::token_t             tok_reg;
    swerl_pkg::token_t             tok_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [swerl_pkg::STAMP_W-1:0] age;
    logic                          young;

    // Age wraps modulo 2^32.
    assign age   = tok_in.now - stamp_reg;
    assign young = valid_reg && (age <= swerl_pkg::STAMP_W'(window_ms));

    always_comb begin
        stamp_next = stamp_reg;
        valid_next = valid_reg;
        tok_next   = tok_in;
        cnt_next   = cnt_in;
        if (tok_in.active) begin
            case (tok_in.kind)
                swerl_pkg::PASS_COUNT: begin
                    cnt_next = cnt_in + CNT_W'(young);
                    // drop an expired grant unless the request is a duplicate
                    if (tok_in.prune && valid_reg && !young) begin
                        valid_next = 1'b0;
                    end
                end
                swerl_pkg::PASS_INSERT: begin
                    // first free slot takes the stamp
                    if (!valid_reg && !tok_in.done) begin
                        valid_next    = 1'b1;
                        stamp_next    = tok_in.now;
                        tok_next.done = 1'b1;
                    end
                end
                default: begin
                    cnt_next = cnt_in;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
        stamp_reg <= stamp_next;
        cnt_reg   <= cnt_next;
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

### hdl/sliding_window_event_rate_limiter_core.sv
// Top level of the sliding-window rate limiter: control and the row of slot cells.
//
//  channel  direction  handshake              beat contents
//  s_       in         s_valid / s_ready      now_ms, frame_number, class_id
//  m_       out        m_valid / m_ready      granted, refuse_cause, count_in_window
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request at a time. A token walks the MAX_EVENTS cells, one per cycle, to
// age, prune and count the log; a refusal then goes through the result registers
// to its result beat. A grant walks the row a second time to store its stamp
// before the next request beat is taken.
// The output register frees the row while a result beat waits on m_ready.
// Reset clears all slots and the last-grant memory; cfg_ready is always high.
`include "assert_macros.svh"

module sliding_window_event_rate_limiter_core #(
    parameter int MAX_EVENTS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [swerl_pkg::STAMP_W-1:0]    s_now_ms,
    input  logic [swerl_pkg::FRAME_W-1:0]    s_frame_number,
    input  logic [swerl_pkg::CLASS_W-1:0]    s_class_id,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_granted,
    output logic [swerl_pkg::CAUSE_W-1:0]    m_refuse_cause,
    output logic [swerl_pkg::COUNT_OUT_W-1:0] m_count_in_window,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [swerl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swerl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam int EXT_W = (CNT_W > swerl_pkg::COUNT_OUT_W) ? CNT_W : swerl_pkg::COUNT_OUT_W;

    swerl_pkg::state_t             state_reg;
    swerl_pkg::state_t             state_next;
    swerl_pkg::token_t             launch_reg;
    swerl_pkg::token_t             launch_next;

    logic [swerl_pkg::WINDOW_W-1:0] window_reg;
    logic [swerl_pkg::LIMIT_W-1:0]  limit_reg;
    logic [swerl_pkg::STAMP_W-1:0]  now_reg;
    logic [swerl_pkg::FRAME_W-1:0]  frame_reg;
    logic [swerl_pkg::CLASS_W-1:0]  class_reg;
    logic                           dup_reg;
    logic [swerl_pkg::FRAME_W-1:0]  last_frame_reg;
    logic [swerl_pkg::CLASS_W-1:0]  last_class_reg;
    logic                           last_seen_reg;

    logic                           res_granted_reg;
    logic [swerl_pkg::CAUSE_W-1:0]  res_cause_reg;
    logic [EXT_W-1:0]               res_count_reg;

    logic                            m_valid_reg;
    logic                            m_granted_reg;
    logic [swerl_pkg::CAUSE_W-1:0]   m_cause_reg;
    logic [swerl_pkg::COUNT_OUT_W-1:0] m_count_reg;

    swerl_pkg::token_t tok [MAX_EVENTS+1];
    logic [CNT_W-1:0]  cnt [MAX_EVENTS+1];

    logic             in_fire;
    logic             dup_now;
    logic             tail_done;
    logic [EXT_W-1:0] tail_cnt;
    logic [EXT_W-1:0] lim_ext;
    logic [EXT_W-1:0] eff_limit;
    logic             full;
    logic             grant;
    logic             load_res;
    logic             out_free;
    logic             load_out;

    // ---------------- cell row ----------------
    assign tok[0] = launch_reg;
    assign cnt[0] = '0;

    for (genvar g = 0; g < MAX_EVENTS; g++) begin : g_cell
        swerl_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .window_ms (window_reg),
            .tok_in    (tok[g]),
            .cnt_in    (cnt[g]),
            .tok_out   (tok[g+1]),
            .cnt_out   (cnt[g+1])
        );
    end

    // ---------------- decision ----------------
    assign in_fire   = s_valid && s_ready;
    assign dup_now   = last_seen_reg && (s_frame_number == last_frame_reg)
                       && (s_class_id == last_class_reg);
    assign tail_done = tok[MAX_EVENTS].active;
    assign tail_cnt  = EXT_W'(cnt[MAX_EVENTS]);
    assign lim_ext   = EXT_W'(limit_reg);
    assign eff_limit = (lim_ext > EXT_W'(MAX_EVENTS)) ? EXT_W'(MAX_EVENTS) : lim_ext;
    assign full      = (tail_cnt >= eff_limit);
    assign grant     = !dup_reg && !full;
    assign out_free  = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swerl_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = swerl_pkg::ST_SWEEP;
                end
            end
            swerl_pkg::ST_SWEEP: begin
                if (tail_done) begin
                    state_next = grant ? swerl_pkg::ST_INSERT : swerl_pkg::ST_EMIT;
                end
            end
            swerl_pkg::ST_INSERT: begin
                if (tail_done) begin
                    state_next = swerl_pkg::ST_EMIT;
                end
            end
            swerl_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = swerl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swerl_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready            = 1'b0;
        load_res           = 1'b0;
        load_out           = 1'b0;
        launch_next        = '0;
        launch_next.kind   = swerl_pkg::PASS_COUNT;
        case (state_reg)
            swerl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    launch_next.active = 1'b1;
                    launch_next.kind   = swerl_pkg::PASS_COUNT;
                    launch_next.prune  = !dup_now;
                    launch_next.now    = s_now_ms;
                end
            end
            swerl_pkg::ST_SWEEP: begin
                load_res = tail_done;
                if (tail_done && grant) begin
                    launch_next.active = 1'b1;
                    launch_next.kind   = swerl_pkg::PASS_INSERT;
                    launch_next.now    = now_reg;
                end
            end
            swerl_pkg::ST_INSERT: begin
                load_res = 1'b0;
            end
            swerl_pkg::ST_EMIT: begin
                load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= swerl_pkg::ST_IDLE;
            launch_reg    <= '0;
            window_reg    <= swerl_pkg::WINDOW_RESET;
            limit_reg     <= swerl_pkg::LIMIT_RESET;
            last_frame_reg <= '0;
            last_class_reg <= '0;
            last_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    swerl_pkg::REG_WINDOW_MS: begin
                        window_reg <= cfg_data[swerl_pkg::WINDOW_W-1:0];
                    end
                    swerl_pkg::REG_MAX_PER_WINDOW: begin
                        limit_reg <= cfg_data[swerl_pkg::LIMIT_W-1:0];
                    end
                    default: begin
                        limit_reg <= limit_reg;
                    end
                endcase
            end

            // remember the last granted frame and class
            if (load_res && grant) begin
                last_frame_reg <= frame_reg;
                last_class_reg <= class_reg;
                last_seen_reg  <= 1'b1;
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (in_fire) begin
            now_reg   <= s_now_ms;
            frame_reg <= s_frame_number;
            class_reg <= s_class_id;
            dup_reg   <= dup_now;
        end

        if (load_res) begin
            res_granted_reg <= grant;
            if (dup_reg) begin
                res_cause_reg <= swerl_pkg::CAUSE_DUP;
                res_count_reg <= tail_cnt;
            end else if (full) begin
                res_cause_reg <= swerl_pkg::CAUSE_FULL;
                res_count_reg <= tail_cnt;
            end else begin
                res_cause_reg <= swerl_pkg::CAUSE_NONE;
                res_count_reg <= tail_cnt + EXT_W'(1);
            end
        end

        if (load_out) begin
            m_granted_reg <= res_granted_reg;
            m_cause_reg   <= res_cause_reg;
            m_count_reg   <= res_count_reg[swerl_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_granted         = m_granted_reg;
    assign m_refuse_cause    = m_cause_reg;
    assign m_count_in_window = m_count_reg;

    // ---------------- assertions ----------------
    `ASSERT_IMPLY(a_tail_only_busy, aclk, aresetn, tok[MAX_EVENTS].active, state_reg == swerl_pkg::ST_SWEEP || state_reg == swerl_pkg::ST_INSERT)
    `ASSERT_IMPLY(a_grant_no_cause, aclk, aresetn, m_valid_reg, m_granted_reg == (m_cause_reg == swerl_pkg::CAUSE_NONE))
    `ASSERT_NEXT(a_emit_to_idle, aclk, aresetn, state_reg == swerl_pkg::ST_EMIT && out_free, state_reg == swerl_pkg::ST_IDLE && m_valid_reg)
    `ASSERT_IMPLY(a_launch_idle_only, aclk, aresetn, launch_reg.active && launch_reg.kind == swerl_pkg::PASS_COUNT, state_reg == swerl_pkg::ST_SWEEP)

endmodule

### tb/sv/sliding_window_event_rate_limiter_core_tb.sv
// Self-checking testbench for the sliding-window rate limiter core.
`timescale 1ns / 1ps

module sliding_window_event_rate_limiter_core_tb;

    localparam int SLOTS        = 32;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYC   = 2 * SLOTS + 8;
    localparam int PHASE_ITEMS  = 120;
    localparam int NUM_PHASES   = 9;
    localparam int PRESSURE_PH  = 4;
    localparam int MAX_PRINTS   = 25;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [swerl_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                              granted;
        logic [swerl_pkg::CAUSE_W-1:0]     cause;
        logic [swerl_pkg::COUNT_OUT_W-1:0] count;
    } decision_t;

    logic                              aclk;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [swerl_pkg::STAMP_W-1:0]     s_now_ms = '0;
    logic [swerl_pkg::FRAME_W-1:0]     s_frame_number = '0;
    logic [swerl_pkg::CLASS_W-1:0]     s_class_id = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic                              m_granted;
    logic [swerl_pkg::CAUSE_W-1:0]     m_refuse_cause;
    logic [swerl_pkg::COUNT_OUT_W-1:0] m_count_in_window;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [swerl_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [swerl_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;

    class grant_scoreboard;
        logic [swerl_pkg::STAMP_W-1:0]  stamp [SLOTS];
        bit                             live [SLOTS];
        logic [swerl_pkg::FRAME_W-1:0]  last_frame;
        logic [swerl_pkg::CLASS_W-1:0]  last_class;
        bit                             have_grant;
        logic [swerl_pkg::WINDOW_W-1:0] window_ms;
        logic [swerl_pkg::LIMIT_W-1:0]  limit;
        decision_t                      decisions_q[$];
        int errors, requests, results, grants, dups, fulls, settings;

        function new();
            foreach (live[i]) begin
                live[i] = 1'b0;
                stamp[i] = '0;
            end
            last_frame = '0;
            last_class = '0;
            have_grant = 1'b0;
            window_ms = swerl_pkg::WINDOW_RESET;
            limit = swerl_pkg::LIMIT_RESET;
            settings = 1;
        endfunction

        function void set_reg(logic [swerl_pkg::CFG_IDX_W-1:0] idx,
                              logic [swerl_pkg::CFG_DATA_W-1:0] data);
            if (idx == swerl_pkg::REG_WINDOW_MS) begin
                window_ms = data;
            end else if (idx == swerl_pkg::REG_MAX_PER_WINDOW) begin
                limit = data[swerl_pkg::LIMIT_W-1:0];
            end
        endfunction

        function bit young(logic [swerl_pkg::STAMP_W-1:0] now,
                           logic [swerl_pkg::STAMP_W-1:0] t);
            logic [swerl_pkg::STAMP_W-1:0] age;
            age = now - t;
            return age <= swerl_pkg::STAMP_W'(window_ms);
        endfunction

        function void note_request(logic [swerl_pkg::STAMP_W-1:0] now,
                                   logic [swerl_pkg::FRAME_W-1:0] frame,
                                   logic [swerl_pkg::CLASS_W-1:0] cls);
            int unsigned n;
            int unsigned cap;
            decision_t   d;
            n = 0;
            cap = (limit > SLOTS) ? SLOTS : limit;
            requests++;
            if (have_grant && frame == last_frame && cls == last_class) begin
                // Same frame and class as the last grant: count only, no pruning.
                foreach (live[i])
                    if (live[i] && young(now, stamp[i])) n++;
                d.granted = 1'b0;
                d.cause = swerl_pkg::CAUSE_DUP;
                dups++;
            end else begin
                foreach (live[i]) begin
                    if (live[i]) begin
                        if (young(now, stamp[i])) n++;
                        else live[i] = 1'b0;
                    end
                end
                if (n >= cap) begin
                    d.granted = 1'b0;
                    d.cause = swerl_pkg::CAUSE_FULL;
                    fulls++;
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!live[i]) begin
                            live[i] = 1'b1;
                            stamp[i] = now;
                            break;
                        end
                    end
                    n++;
                    last_frame = frame;
                    last_class = cls;
                    have_grant = 1'b1;
                    d.granted = 1'b1;
                    d.cause = swerl_pkg::CAUSE_NONE;
                    grants++;
                end
            end
            d.count = n[swerl_pkg::COUNT_OUT_W-1:0];
            decisions_q.push_back(d);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            if (errors < MAX_PRINTS)
                $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                         results, what, got, want);
            errors++;
        endtask

        task check_decision(logic g, logic [swerl_pkg::CAUSE_W-1:0] cause,
                            logic [swerl_pkg::COUNT_OUT_W-1:0] cnt);
            decision_t want;
            if (decisions_q.size() == 0) begin
                report_mismatch("result beat with nothing pending",
                                64'({g, cause, cnt}), 64'd0);
                return;
            end
            want = decisions_q.pop_front();
            if (g !== want.granted)
                report_mismatch("granted", 64'(g), 64'(want.granted));
            if (cause !== want.cause)
                report_mismatch("refuse_cause", 64'(cause), 64'(want.cause));
            if (cnt !== want.count)
                report_mismatch("count_in_window", 64'(cnt), 64'(want.count));
            results++;
        endtask

        task check_drained();
            if (decisions_q.size() != 0)
                report_mismatch("results never delivered", 64'd0,
                                64'(decisions_q.size()));
        endtask
    endclass

    grant_scoreboard sb = new();

    sliding_window_event_rate_limiter_core #(.MAX_EVENTS(SLOTS)) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_now_ms          (s_now_ms),
        .s_frame_number    (s_frame_number),
        .s_class_id        (s_class_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted         (m_granted),
        .m_refuse_cause    (m_refuse_cause),
        .m_count_in_window (m_count_in_window),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: check every beat, stall in short bursts or one long hold.
    initial begin : result_sink
        int hold;
        hold = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_decision(m_granted, m_refuse_cause, m_count_in_window);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no beat for %0d cycles, %0d results still pending",
                 STALL_LIMIT, sb.decisions_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Optionally drop valid for a gap first; hold valid and payload until the beat goes through; leave valid high.
    task automatic send_request(logic [swerl_pkg::STAMP_W-1:0] now,
                                logic [swerl_pkg::FRAME_W-1:0] frame,
                                logic [swerl_pkg::CLASS_W-1:0] cls);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_now_ms <= now;
        s_frame_number <= frame;
        s_class_id <= cls;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(now, frame, cls);
    endtask

    task automatic write_reg(logic [swerl_pkg::CFG_IDX_W-1:0] idx,
                             logic [swerl_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_config(logic [swerl_pkg::CFG_DATA_W-1:0] win,
                                logic [swerl_pkg::CFG_DATA_W-1:0] lim);
        write_reg(swerl_pkg::REG_WINDOW_MS, win);
        write_reg(swerl_pkg::REG_MAX_PER_WINDOW, lim);
        cfg_valid <= 1'b0;
        sb.settings++;
    endtask

    // Drop valid, drain all pending results, then hold the request side idle.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.decisions_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic run_random_phase(int items, bit pressure);
        logic [swerl_pkg::STAMP_W-1:0] now;
        logic [swerl_pkg::STAMP_W-1:0] step;
        logic [swerl_pkg::FRAME_W-1:0] frame;
        logic [swerl_pkg::CLASS_W-1:0] cls;
        int unsigned cap;
        int unsigned span;
        int unsigned pick;
        cap = (sb.limit > SLOTS) ? SLOTS : sb.limit;
        if (cap == 0) cap = 1;
        span = sb.window_ms / cap;
        if (span == 0) span = 1;
        // Start either anywhere or just short of the 2^32 wrap.
        now = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 4000);
        frame = $urandom();
        cls = swerl_pkg::CLASS_W'($urandom_range(0, 3));
        for (int k = 0; k < items; k++) begin
            if (pressure && k == 20) long_hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 60)      step = $urandom_range(0, 2 * span);
            else if (pick < 75) step = '0;
            else if (pick < 90) step = swerl_pkg::STAMP_W'(sb.window_ms)
                                       + $urandom_range(0, 2) - 1;
            else                step = $urandom();
            now = now + step;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                frame = sb.last_frame;
                cls = sb.last_class;
            end else if (pick < 60) begin
                frame = frame + $urandom_range(0, 1);
                cls = swerl_pkg::CLASS_W'($urandom_range(0, 3));
            end else if (pick < 85) begin
                frame = frame + 1;
                cls = swerl_pkg::CLASS_W'($urandom_range(0, 255));
            end else begin
                frame = $urandom();
                cls = swerl_pkg::CLASS_W'($urandom_range(0, 255));
            end
            send_request(now, frame, cls);
        end
    endtask

    initial begin : stimulus
        logic [swerl_pkg::CFG_DATA_W-1:0] win_tab [NUM_PHASES];
        logic [swerl_pkg::CFG_DATA_W-1:0] lim_tab [NUM_PHASES];
        bit                               idle_tab [NUM_PHASES];

        win_tab = '{16'd1000, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd50, 16'd0, 16'd7, 16'd1000};
        lim_tab = '{16'd20, 16'd63, 16'd1, 16'd32, 16'd0, 16'hFFC4, 16'd0, 16'd32, 16'd20};
        idle_tab = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
        win_tab[4] = swerl_pkg::CFG_DATA_W'($urandom_range(1, 300));
        lim_tab[4] = swerl_pkg::CFG_DATA_W'($urandom_range(1, 32));
        win_tab[6] = swerl_pkg::CFG_DATA_W'($urandom_range(1, 65535));
        lim_tab[6] = swerl_pkg::CFG_DATA_W'($urandom_range(0, 63));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: first request is never a duplicate, then modular ages.
        send_request(32'd0, 32'd0, 8'd0);
        send_request(32'd1, 32'd0, 8'd0);
        send_request(32'd2, 32'd0, 8'd1);
        send_request(32'h8000_0002, 32'd0, 8'd1);
        send_request(32'd3, 32'd0, 8'd1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(32'd0, 32'd1, 8'hFF);
        send_request(32'd1000, 32'd2, 8'h80);
        settle();

        // Zero window and a small limit: fill, refuse, then age out.
        apply_config(16'd0, 16'd3);
        for (int f = 10; f < 14; f++)
            send_request(32'd100, swerl_pkg::FRAME_W'(f), 8'h55);
        send_request(32'd101, 32'd14, 8'hAA);
        settle();

        // Limit zero, plus a write to an index with no register.
        write_reg(REG_SPARE, 16'h1234);
        apply_config(16'd65535, 16'd0);
        send_request(32'd200, 32'd20, 8'd1);
        send_request(32'd101, 32'd14, 8'hAA);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_on = idle_tab[p];
            apply_config(win_tab[p], lim_tab[p]);
            run_random_phase(PHASE_ITEMS, p == PRESSURE_PH);
            settle();
        end

        sb.check_drained();
        $display("Ran %0d requests under %0d limiter settings: %0d granted, %0d duplicate",
                 sb.requests, sb.settings, sb.grants, sb.dups);
        $display("refusals, %0d window-full refusals; %0d results checked, %0d mismatches.",
                 sb.fulls, sb.results, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
